@@ hw/rtl/cbpt_pkg.sv @@
package cbpt_pkg;

   localparam int COORD_BITS_DEF    = 16;
   localparam int PARAM_BITS_DEF    = 16;
   localparam int DIR_FRAC_BITS_DEF = 14;

   // only the low 64 bits of a control point register are seen by the datapath
   localparam int REG_VISIBLE_BITS = 64;
   localparam int NUM_CTRL         = 4;

   // normalised derivative magnitude lies in [2^NORM_MSB, 2^(NORM_MSB+1))
   localparam int MAG_BITS  = 30;
   localparam int NORM_MSB  = MAG_BITS - 1;
   localparam int ROOT_BITS = 32;
   localparam int RAD_BITS  = 2 * ROOT_BITS;

   localparam int STEPS_PER_STAGE = 2;

   localparam int CSR_INDEX_BITS = 3;
   typedef logic [CSR_INDEX_BITS-1:0] csr_index_type;

   localparam csr_index_type CSR_CTRL_POINT_0 = csr_index_type'(0);
   localparam csr_index_type CSR_CTRL_POINT_1 = csr_index_type'(1);
   localparam csr_index_type CSR_CTRL_POINT_2 = csr_index_type'(2);
   localparam csr_index_type CSR_CTRL_POINT_3 = csr_index_type'(3);

endpackage

@@ hw/rtl/cbpt_req_if.sv @@
interface cbpt_req_if #(
   parameter int PARAM_BITS    = cbpt_pkg::PARAM_BITS_DEF,
   parameter int DIR_FRAC_BITS = cbpt_pkg::DIR_FRAC_BITS_DEF
);
   logic                          valid;
   logic                          ready;
   logic [PARAM_BITS:0]           param_u;
   logic                          has_prev_dir;
   logic signed [DIR_FRAC_BITS+1:0] prev_dir_x;
   logic signed [DIR_FRAC_BITS+1:0] prev_dir_y;
   logic signed [DIR_FRAC_BITS+1:0] prev_dir_z;

   modport source (output valid, output param_u, output has_prev_dir,
                   output prev_dir_x, output prev_dir_y, output prev_dir_z,
                   input ready);
   modport sink (input valid, input param_u, input has_prev_dir,
                 input prev_dir_x, input prev_dir_y, input prev_dir_z,
                 output ready);
endinterface

@@ hw/rtl/cbpt_rsp_if.sv @@
interface cbpt_rsp_if #(
   parameter int COORD_BITS    = cbpt_pkg::COORD_BITS_DEF,
   parameter int DIR_FRAC_BITS = cbpt_pkg::DIR_FRAC_BITS_DEF
);
   logic                            valid;
   logic                            ready;
   logic signed [COORD_BITS-1:0]    pos_x;
   logic signed [COORD_BITS-1:0]    pos_y;
   logic signed [COORD_BITS-1:0]    pos_z;
   logic signed [DIR_FRAC_BITS+1:0] dir_x;
   logic signed [DIR_FRAC_BITS+1:0] dir_y;
   logic signed [DIR_FRAC_BITS+1:0] dir_z;
   logic signed [DIR_FRAC_BITS+1:0] rate_x;
   logic signed [DIR_FRAC_BITS+1:0] rate_y;
   logic signed [DIR_FRAC_BITS+1:0] rate_z;

   modport source (output valid, output pos_x, output pos_y, output pos_z,
                   output dir_x, output dir_y, output dir_z,
                   output rate_x, output rate_y, output rate_z,
                   input ready);
   modport sink (input valid, input pos_x, input pos_y, input pos_z,
                 input dir_x, input dir_y, input dir_z,
                 input rate_x, input rate_y, input rate_z,
                 output ready);
endinterface

@@ hw/rtl/cbpt_isqrt.sv @@
module cbpt_isqrt (
   input  logic                               clock,
   input  logic                               en,
   input  logic [cbpt_pkg::RAD_BITS-1:0]      rad_in,
   output logic [cbpt_pkg::ROOT_BITS-1:0]     root_out
);
   localparam int NW   = cbpt_pkg::RAD_BITS;
   localparam int RW   = cbpt_pkg::ROOT_BITS;
   localparam int REMW = RW + 2;
   localparam int SPS  = cbpt_pkg::STEPS_PER_STAGE;
   localparam int STG  = RW / SPS;

   logic [NW-1:0]   rad_ff  [STG];
   logic [RW-1:0]   root_ff [STG];
   logic [REMW-1:0] rem_ff  [STG];

   for (genvar gs = 0; gs < STG; gs++) begin : g_stage
      logic [NW-1:0]   rad_src, rad_nx;
      logic [RW-1:0]   root_src, root_nx;
      logic [REMW-1:0] rem_src, rem_nx;

      if (gs == 0) begin : g_first
         assign rad_src  = rad_in;
         assign root_src = '0;
         assign rem_src  = '0;
      end else begin : g_next
         assign rad_src  = rad_ff[gs-1];
         assign root_src = root_ff[gs-1];
         assign rem_src  = rem_ff[gs-1];
      end

      always_comb begin
         logic [REMW-1:0] rs;
         logic [REMW-1:0] tr;
         rad_nx  = rad_src;
         root_nx = root_src;
         rem_nx  = rem_src;
         for (int j = 0; j < SPS; j++) begin
            rs     = {rem_nx[REMW-3:0], rad_nx[NW-1:NW-2]};
            rad_nx = rad_nx << 2;
            tr     = {root_nx, 2'b01};
            if (rs >= tr) begin
               rem_nx  = rs - tr;
               root_nx = {root_nx[RW-2:0], 1'b1};
            end else begin
               rem_nx  = rs;
               root_nx = {root_nx[RW-2:0], 1'b0};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            rad_ff[gs]  <= rad_nx;
            root_ff[gs] <= root_nx;
            rem_ff[gs]  <= rem_nx;
         end
      end
   end

   assign root_out = root_ff[STG-1];

endmodule

@@ hw/rtl/cbpt_div.sv @@
module cbpt_div #(
   parameter int FRAC_BITS = cbpt_pkg::DIR_FRAC_BITS_DEF
) (
   input  logic                           clock,
   input  logic                           en,
   input  logic [cbpt_pkg::MAG_BITS-1:0]  mag_in,
   input  logic [cbpt_pkg::ROOT_BITS-1:0] den_in,
   output logic [FRAC_BITS:0]             quo_out
);
   localparam int MW   = cbpt_pkg::MAG_BITS;
   localparam int DNW  = cbpt_pkg::ROOT_BITS;
   localparam int QB   = FRAC_BITS + 1;
   localparam int NUMW = MW + QB;
   localparam int SPS  = cbpt_pkg::STEPS_PER_STAGE;
   localparam int STG  = (QB + SPS - 1) / SPS;

   logic [NUMW-1:0] num_ff;
   logic [DNW-1:0]  den0_ff;

   logic [DNW:0]    pr_ff [STG];
   logic [QB-1:0]   lo_ff [STG];
   logic [QB-1:0]   q_ff  [STG];
   logic [DNW-1:0]  dn_ff [STG];

   // numerator with half the divisor added for round to nearest
   always_ff @(posedge clock) begin
      if (en) begin
         num_ff  <= NUMW'({mag_in, {FRAC_BITS{1'b0}}}) + NUMW'(den_in >> 1);
         den0_ff <= den_in;
      end
   end

   for (genvar gs = 0; gs < STG; gs++) begin : g_stage
      logic [DNW:0]   pr_src, pr_nx;
      logic [QB-1:0]  lo_src, lo_nx, q_src, q_nx;
      logic [DNW-1:0] dn_src;

      if (gs == 0) begin : g_first
         assign pr_src = (DNW+1)'(num_ff[NUMW-1:QB]);
         assign lo_src = num_ff[QB-1:0];
         assign q_src  = '0;
         assign dn_src = den0_ff;
      end else begin : g_next
         assign pr_src = pr_ff[gs-1];
         assign lo_src = lo_ff[gs-1];
         assign q_src  = q_ff[gs-1];
         assign dn_src = dn_ff[gs-1];
      end

      always_comb begin
         logic [DNW:0] t_v;
         t_v   = '0;
         pr_nx = pr_src;
         lo_nx = lo_src;
         q_nx  = q_src;
         for (int j = 0; j < SPS; j++) begin
            if (gs * SPS + j < QB) begin
               t_v   = {pr_nx[DNW-1:0], lo_nx[QB-1]};
               lo_nx = lo_nx << 1;
               if (t_v >= {1'b0, dn_src}) begin
                  pr_nx = t_v - {1'b0, dn_src};
                  q_nx  = {q_nx[QB-2:0], 1'b1};
               end else begin
                  pr_nx = t_v;
                  q_nx  = {q_nx[QB-2:0], 1'b0};
               end
            end
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            pr_ff[gs] <= pr_nx;
            lo_ff[gs] <= lo_nx;
            q_ff[gs]  <= q_nx;
            dn_ff[gs] <= dn_src;
         end
      end
   end

   assign quo_out = q_ff[STG-1];

endmodule

@@ hw/rtl/cubic_bezier_point_and_tangent.sv @@
// Cubic Bezier point and unit tangent.
// Control points P0..P3 are written on the csr_ port (index 0..3, packed
// x,y,z); other indexes are ignored. Write them only while no item is in
// flight. Each req_chan item carries u (Q1.PARAM_BITS, saturated to one),
// a flag and a previous direction; each rsp_chan item returns the curve
// point, the unit tangent (Q1.DIR_FRAC_BITS) and the rate vector.
// Throughput: one item per cycle, no gaps, unless rsp stalls; data-independent.
// Pipeline: 8 + 16 + (1 + ceil((DIR_FRAC_BITS+1)/2)) + 1 register stages, 34 at
// the default widths, set by the Horner and normalising front end (8 stages),
// the square root pipeline (two root bits per stage), the three parallel
// divider lanes (two quotient bits per stage) and the output register.
// The pipeline moves as one: when rsp valid is high and rsp ready low, all
// stages hold and req ready is low; bubbles in flight are kept.
// Reset clears the control points to zero and empties the pipeline.
module cubic_bezier_point_and_tangent #(
   parameter int COORD_BITS    = cbpt_pkg::COORD_BITS_DEF,
   parameter int PARAM_BITS    = cbpt_pkg::PARAM_BITS_DEF,
   parameter int DIR_FRAC_BITS = cbpt_pkg::DIR_FRAC_BITS_DEF
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_wr_en,
   input  cbpt_pkg::csr_index_type     csr_index,
   input  logic [3*COORD_BITS-1:0]     csr_wdata,
   cbpt_req_if.sink                    req_chan,
   cbpt_rsp_if.source                  rsp_chan
);
   localparam int CW    = COORD_BITS;
   localparam int PW    = PARAM_BITS;
   localparam int F     = DIR_FRAC_BITS;
   localparam int FW    = F + 2;
   localparam int UW    = PW + 1;
   localparam int DW    = CW + 6;
   localparam int MW    = cbpt_pkg::MAG_BITS;
   localparam int NRM   = cbpt_pkg::NORM_MSB;
   localparam int XW    = (DW > MW + 1) ? DW : MW + 1;
   localparam int PRW   = DW + UW + 1;
   localparam int REGW  = 3 * CW;
   localparam int VIS   = cbpt_pkg::REG_VISIBLE_BITS;
   localparam int NC    = cbpt_pkg::NUM_CTRL;
   localparam int QB    = F + 1;
   localparam int SPS   = cbpt_pkg::STEPS_PER_STAGE;
   localparam int SQL   = cbpt_pkg::ROOT_BITS / SPS;
   localparam int DVL   = 1 + (QB + SPS - 1) / SPS;
   localparam int NST   = 9 + SQL + DVL;
   localparam int SDL   = 2 + SQL + DVL;
   localparam int DTAP  = 2 + SQL;
   localparam int PBW   = $clog2(DW);

   localparam logic signed [DW-1:0]  K2 = DW'(2);
   localparam logic signed [DW-1:0]  K3 = DW'(3);
   localparam logic signed [DW-1:0]  K6 = DW'(6);
   localparam logic signed [PRW-1:0] RND_HALF = PRW'(1) <<< (PW - 1);
   localparam logic [QB-1:0]         Q_ONE = QB'(1) << F;
   localparam logic signed [FW-1:0]  D_ONE = FW'(1) <<< F;

   typedef struct packed {
      logic                  hp;
      logic [2:0][FW-1:0]    pd;
   } front_type;

   typedef struct packed {
      logic                  zero;
      logic [2:0]            neg;
      logic [2:0][MW-1:0]    mag;
      logic [2:0][CW-1:0]    pos;
      logic                  hp;
      logic [2:0][FW-1:0]    pd;
   } side_type;

   function automatic logic signed [DW-1:0] rmul(input logic signed [DW-1:0] h,
                                                 input logic [UW-1:0] u);
      logic signed [PRW-1:0] prod;
      logic signed [PRW-1:0] rnd;
      prod = PRW'(h) * PRW'(signed'({1'b0, u}));
      rnd  = (prod + RND_HALF) >>> PW;
      return rnd[DW-1:0];
   endfunction

   // control
   logic [NST-1:0] vld_ff;
   logic           en;

   assign en             = !vld_ff[NST-1] || rsp_chan.ready;
   assign req_chan.ready = en;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[NST-2:0], req_chan.valid};
      end
   end

   // control point registers
   logic [REGW-1:0] ctrl_ff [NC];
   logic [REGW-1:0] vis     [NC];

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NC; i++) ctrl_ff[i] <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            cbpt_pkg::CSR_CTRL_POINT_0: ctrl_ff[0] <= csr_wdata;
            cbpt_pkg::CSR_CTRL_POINT_1: ctrl_ff[1] <= csr_wdata;
            cbpt_pkg::CSR_CTRL_POINT_2: ctrl_ff[2] <= csr_wdata;
            cbpt_pkg::CSR_CTRL_POINT_3: ctrl_ff[3] <= csr_wdata;
            default: ;
         endcase
      end
   end

   for (genvar gi = 0; gi < NC; gi++) begin : g_vis
      for (genvar gb = 0; gb < REGW; gb++) begin : g_bit
         if (gb < VIS) begin : g_keep
            assign vis[gi][gb] = ctrl_ff[gi][gb];
         end else begin : g_drop
            assign vis[gi][gb] = 1'b0;
         end
      end
   end

   // power-basis coefficients
   logic signed [DW-1:0] ca_ff [3], cb_ff [3], cc_ff [3], cd_ff [3];
   logic signed [DW-1:0] ca3_ff [3], cb2_ff [3];
   logic signed [DW-1:0] ca_in [3], cb_in [3], cc_in [3], cd_in [3];
   logic signed [DW-1:0] ca3_in [3], cb2_in [3];

   always_comb begin
      logic signed [DW-1:0] p0, p1, p2, p3;
      for (int k = 0; k < 3; k++) begin
         p0 = DW'(signed'(vis[0][k*CW +: CW]));
         p1 = DW'(signed'(vis[1][k*CW +: CW]));
         p2 = DW'(signed'(vis[2][k*CW +: CW]));
         p3 = DW'(signed'(vis[3][k*CW +: CW]));
         ca_in[k]  = K3 * p1 - K3 * p2 + p3 - p0;
         cb_in[k]  = K3 * p0 - K6 * p1 + K3 * p2;
         cc_in[k]  = K3 * (p1 - p0);
         cd_in[k]  = p0;
         ca3_in[k] = K3 * ca_in[k];
         cb2_in[k] = K2 * cb_in[k];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < 3; k++) begin
         ca_ff[k]  <= ca_in[k];
         cb_ff[k]  <= cb_in[k];
         cc_ff[k]  <= cc_in[k];
         cd_ff[k]  <= cd_in[k];
         ca3_ff[k] <= ca3_in[k];
         cb2_ff[k] <= cb2_in[k];
      end
   end

   // front end
   logic [UW-1:0]        u1_ff, u2_ff, u3_ff, u1_in;
   front_type            fr_ff [5];
   front_type            fr_in;
   logic signed [DW-1:0] h1_ff [3], g1_ff [3], h2_ff [3], dv3_ff [3], d4_ff [3];
   logic signed [DW-1:0] h1_in [3], g1_in [3], h2_in [3], dv3_in [3];
   logic [2:0][CW-1:0]   pos4_ff, pos5_ff, pos4_in;
   logic [DW-1:0]        m4_ff, m4_in;
   logic signed [XW-1:0] s5_ff [3], s5_in [3];
   logic                 z5_ff, z5_in;
   side_type             side_in;
   logic [2*MW-1:0]      sq7_ff [3], sq7_in [3];
   logic [cbpt_pkg::RAD_BITS-1:0] n8_ff, n8_in;

   assign u1_in = req_chan.param_u[PW] ? {1'b1, {PW{1'b0}}} : req_chan.param_u;
   assign fr_in = '{hp: req_chan.has_prev_dir,
                    pd: {req_chan.prev_dir_z, req_chan.prev_dir_y, req_chan.prev_dir_x}};

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         h1_in[k]  = cb_ff[k] + rmul(ca_ff[k], u1_ff);
         g1_in[k]  = cb2_ff[k] + rmul(ca3_ff[k], u1_ff);
         h2_in[k]  = cc_ff[k] + rmul(h1_ff[k], u2_ff);
         dv3_in[k] = cc_ff[k] + rmul(g1_ff[k], u2_ff);
      end
   end

   always_comb begin
      logic signed [DW-1:0] h3;
      logic [DW-1:0]        ab;
      m4_in = '0;
      for (int k = 0; k < 3; k++) begin
         h3 = cd_ff[k] + rmul(h2_ff[k], u3_ff);
         if (h3[DW-1:CW-1] == '0 || h3[DW-1:CW-1] == '1) begin
            pos4_in[k] = h3[CW-1:0];
         end else begin
            pos4_in[k] = {h3[DW-1], {(CW-1){~h3[DW-1]}}};
         end
         ab = dv3_ff[k][DW-1] ? -dv3_ff[k] : dv3_ff[k];
         if (ab > m4_in) m4_in = ab;
      end
   end

   always_comb begin
      logic [PBW-1:0] p_v;
      p_v = '0;
      for (int i = 0; i < DW; i++) begin
         if (m4_ff[i]) p_v = PBW'(i);
      end
      z5_in = (m4_ff == '0);
      for (int k = 0; k < 3; k++) begin
         if (int'(p_v) < NRM) begin
            s5_in[k] = XW'(d4_ff[k]) <<< (NRM - int'(p_v));
         end else begin
            s5_in[k] = XW'(d4_ff[k]) >>> (int'(p_v) - NRM);
         end
      end
   end

   // floor scaling of a negative value can land on 2^(NRM+1): one more halving
   always_comb begin
      logic [XW-1:0]        ab;
      logic [XW-1:0]        ab2;
      logic signed [XW-1:0] x2;
      logic                 corr;
      corr = 1'b0;
      for (int k = 0; k < 3; k++) begin
         ab = s5_ff[k][XW-1] ? -s5_ff[k] : s5_ff[k];
         if (ab[XW-1:NRM+1] != '0) corr = 1'b1;
      end
      side_in.zero = z5_ff;
      side_in.pos  = pos5_ff;
      side_in.hp   = fr_ff[4].hp;
      side_in.pd   = fr_ff[4].pd;
      for (int k = 0; k < 3; k++) begin
         x2  = corr ? (s5_ff[k] >>> 1) : s5_ff[k];
         ab2 = x2[XW-1] ? -x2 : x2;
         side_in.mag[k] = ab2[MW-1:0];
         side_in.neg[k] = x2[XW-1];
      end
   end

   side_type side_ff [SDL+1];

   always_comb begin
      for (int k = 0; k < 3; k++) begin
         sq7_in[k] = side_ff[0].mag[k] * side_ff[0].mag[k];
      end
      n8_in = cbpt_pkg::RAD_BITS'(sq7_ff[0]) + cbpt_pkg::RAD_BITS'(sq7_ff[1])
            + cbpt_pkg::RAD_BITS'(sq7_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         u1_ff    <= u1_in;
         u2_ff    <= u1_ff;
         u3_ff    <= u2_ff;
         fr_ff[0] <= fr_in;
         for (int i = 1; i < 5; i++) fr_ff[i] <= fr_ff[i-1];
         for (int k = 0; k < 3; k++) begin
            h1_ff[k]  <= h1_in[k];
            g1_ff[k]  <= g1_in[k];
            h2_ff[k]  <= h2_in[k];
            dv3_ff[k] <= dv3_in[k];
            d4_ff[k]  <= dv3_ff[k];
            s5_ff[k]  <= s5_in[k];
            sq7_ff[k] <= sq7_in[k];
         end
         pos4_ff    <= pos4_in;
         pos5_ff    <= pos4_ff;
         m4_ff      <= m4_in;
         z5_ff      <= z5_in;
         n8_ff      <= n8_in;
         side_ff[0] <= side_in;
         for (int i = 1; i <= SDL; i++) side_ff[i] <= side_ff[i-1];
      end
   end

   // square root and division
   logic [cbpt_pkg::ROOT_BITS-1:0] root;
   logic [QB-1:0]                  quo [3];

   cbpt_isqrt u_isqrt (
      .clock    (clock),
      .en       (en),
      .rad_in   (n8_ff),
      .root_out (root)
   );

   for (genvar gk = 0; gk < 3; gk++) begin : g_lane
      cbpt_div #(
         .FRAC_BITS (F)
      ) u_div (
         .clock   (clock),
         .en      (en),
         .mag_in  (side_ff[DTAP].mag[gk]),
         .den_in  (root),
         .quo_out (quo[gk])
      );
   end

   // output register
   logic [2:0][CW-1:0] pos_o_ff;
   logic [2:0][FW-1:0] dir_o_ff, rate_o_ff, dir_o_in, rate_o_in;

   always_comb begin
      logic [QB-1:0] qc;
      for (int k = 0; k < 3; k++) begin
         qc = (quo[k] > Q_ONE) ? Q_ONE : quo[k];
         if (side_ff[SDL].zero) begin
            dir_o_in[k] = '0;
         end else if (side_ff[SDL].neg[k]) begin
            dir_o_in[k] = -FW'(qc);
         end else begin
            dir_o_in[k] = FW'(qc);
         end
         rate_o_in[k] = side_ff[SDL].hp ? side_ff[SDL].pd[k] : dir_o_in[k];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         pos_o_ff  <= side_ff[SDL].pos;
         dir_o_ff  <= dir_o_in;
         rate_o_ff <= rate_o_in;
      end
   end

   assign rsp_chan.valid  = vld_ff[NST-1];
   assign rsp_chan.pos_x  = signed'(pos_o_ff[0]);
   assign rsp_chan.pos_y  = signed'(pos_o_ff[1]);
   assign rsp_chan.pos_z  = signed'(pos_o_ff[2]);
   assign rsp_chan.dir_x  = signed'(dir_o_ff[0]);
   assign rsp_chan.dir_y  = signed'(dir_o_ff[1]);
   assign rsp_chan.dir_z  = signed'(dir_o_ff[2]);
   assign rsp_chan.rate_x = signed'(rate_o_ff[0]);
   assign rsp_chan.rate_y = signed'(rate_o_ff[1]);
   assign rsp_chan.rate_z = signed'(rate_o_ff[2]);

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      !en |=> $stable(vld_ff))
      else $error("pipeline valid bits moved during stall");

   a_advance: assert property (@(posedge clock) disable iff (reset)
      en |=> vld_ff[NST-1] == $past(vld_ff[NST-2]))
      else $error("item lost or repeated at output stage");

   a_dir_range: assert property (@(posedge clock) disable iff (reset)
      vld_ff[NST-1] |->
         signed'(dir_o_ff[0]) <= D_ONE && signed'(dir_o_ff[0]) >= -D_ONE &&
         signed'(dir_o_ff[1]) <= D_ONE && signed'(dir_o_ff[1]) >= -D_ONE &&
         signed'(dir_o_ff[2]) <= D_ONE && signed'(dir_o_ff[2]) >= -D_ONE)
      else $error("tangent component beyond unit");

endmodule

@@ verif/tb_cubic_bezier_point_and_tangent.sv @@
module tb_cubic_bezier_point_and_tangent;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int CB = cbpt_pkg::COORD_BITS_DEF;
   localparam int PB = cbpt_pkg::PARAM_BITS_DEF;
   localparam int FB = cbpt_pkg::DIR_FRAC_BITS_DEF;
   localparam int NCP = cbpt_pkg::NUM_CTRL;
   localparam int DW = FB + 2;
   localparam longint U_ONE = 64'sd1 << PB;
   localparam longint DIR_ONE = 64'sd1 << FB;
   localparam int SETTLE = 40;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      logic signed [CB-1:0] pos_x, pos_y, pos_z;
      logic signed [DW-1:0] dir_x, dir_y, dir_z;
      logic signed [DW-1:0] rate_x, rate_y, rate_z;
   } curve_sample_type;

   typedef struct {
      logic [PB:0]             u;
      logic                    flag;
      logic [DW-1:0]           px, py, pz;
      bit                      typed;
   } stim_row_type;

   logic clock;
   logic reset;
   logic csr_wr_en;
   cbpt_pkg::csr_index_type csr_index;
   logic [3*CB-1:0] csr_wdata;

   cbpt_req_if req ();
   cbpt_rsp_if rsp ();

   cubic_bezier_point_and_tangent uut (
      .clock(clock), .reset(reset), .csr_wr_en(csr_wr_en), .csr_index(csr_index),
      .csr_wdata(csr_wdata), .req_chan(req), .rsp_chan(rsp)
   );

   logic [3*CB-1:0]  ctrl_pts [NCP];
   curve_sample_type expected_samples [$];
   int errors = 0;
   int idle_cycles = 0;
   bit no_idle = 0;
   bit hold_off_req = 0;
   bit typed_now = 0;

   initial begin
      clock = 0;
      forever #1 clock = ~clock;
   end

   function automatic longint round_mul(longint h, longint u);
      return (h * u + (U_ONE >>> 1)) >>> PB;
   endfunction

   function automatic curve_sample_type bezier_eval(logic [PB:0] u_in, logic flag,
                                                    logic [DW-1:0] px, logic [DW-1:0] py,
                                                    logic [DW-1:0] pz);
      longint u, a, b, c, h, m, q, p [4], d [3], dirv [3], pos [3];
      longint unsigned n, r, bitv, rem;
      logic [DW-1:0] prev [3];
      curve_sample_type s;
      prev[0] = px; prev[1] = py; prev[2] = pz;
      u = (u_in > U_ONE) ? U_ONE : longint'(u_in);
      for (int k = 0; k < 3; k++) begin
         for (int j = 0; j < NCP; j++)
            p[j] = longint'($signed(ctrl_pts[j][CB*k +: CB]));
         a = -p[0] + 3*p[1] - 3*p[2] + p[3];
         b = 3*p[0] - 6*p[1] + 3*p[2];
         c = 3*(p[1] - p[0]);
         h = b + round_mul(a, u);
         h = c + round_mul(h, u);
         h = p[0] + round_mul(h, u);
         if (h > 32767) h = 32767;
         if (h < -32768) h = -32768;
         pos[k] = h;
         h = 2*b + round_mul(3*a, u);
         d[k] = c + round_mul(h, u);
      end
      m = 0;
      for (int k = 0; k < 3; k++)
         if ((d[k] < 0 ? -d[k] : d[k]) > m) m = d[k] < 0 ? -d[k] : d[k];
      if (m == 0) begin
         dirv[0] = 0; dirv[1] = 0; dirv[2] = 0;
      end else begin
         while (m >= (64'sd1 << 30)) begin
            m = 0;
            for (int k = 0; k < 3; k++) begin
               d[k] = d[k] >>> 1;
               if ((d[k] < 0 ? -d[k] : d[k]) > m) m = d[k] < 0 ? -d[k] : d[k];
            end
         end
         while (m < (64'sd1 << 29)) begin
            for (int k = 0; k < 3; k++) d[k] = d[k] * 2;
            m = m * 2;
         end
         n = 0;
         for (int k = 0; k < 3; k++) n += longint'(d[k] * d[k]);
         r = 0;
         rem = n;
         bitv = 64'd1 << 62;
         while (bitv > rem) bitv >>= 2;
         while (bitv != 0) begin
            if (rem >= r + bitv) begin
               rem -= r + bitv;
               r = (r >> 1) + bitv;
            end else begin
               r >>= 1;
            end
            bitv >>= 2;
         end
         for (int k = 0; k < 3; k++) begin
            q = (((d[k] < 0 ? -d[k] : d[k]) << FB) + longint'(r >> 1))
                / longint'(r);
            if (q > DIR_ONE) q = DIR_ONE;
            dirv[k] = d[k] < 0 ? -q : q;
         end
      end
      s.pos_x = pos[0][CB-1:0]; s.pos_y = pos[1][CB-1:0]; s.pos_z = pos[2][CB-1:0];
      s.dir_x = dirv[0][DW-1:0]; s.dir_y = dirv[1][DW-1:0]; s.dir_z = dirv[2][DW-1:0];
      s.rate_x = flag ? prev[0] : dirv[0][DW-1:0];
      s.rate_y = flag ? prev[1] : dirv[1][DW-1:0];
      s.rate_z = flag ? prev[2] : dirv[2][DW-1:0];
      return s;
   endfunction

   // register model, expectations and response check, all sampled at the edge
   always @(posedge clock) begin
      curve_sample_type e, typed_e;
      if (reset) begin
         for (int j = 0; j < NCP; j++) ctrl_pts[j] = '0;
      end else begin
         if (csr_wr_en && csr_index <= cbpt_pkg::CSR_CTRL_POINT_3)
            ctrl_pts[csr_index] = csr_wdata;
         if (req.valid && req.ready) begin
            e = bezier_eval(req.param_u, req.has_prev_dir, req.prev_dir_x, req.prev_dir_y,
                            req.prev_dir_z);
            if (typed_now) begin
               // all control points zero: curve and tangent vanish
               typed_e = '0;
               if (req.has_prev_dir) begin
                  typed_e.rate_x = req.prev_dir_x;
                  typed_e.rate_y = req.prev_dir_y;
                  typed_e.rate_z = req.prev_dir_z;
               end
               e = typed_e;
            end
            expected_samples = {expected_samples, e};
         end
         if (rsp.valid && rsp.ready) begin
            if (expected_samples.size() == 0) begin
               $error("unexpected item on rsp");
               errors++;
            end else begin
               e = expected_samples.pop_front();
               if (rsp.pos_x !== e.pos_x) begin
                  $error("pos_x exp %0d got %0d", e.pos_x, rsp.pos_x); errors++;
               end
               if (rsp.pos_y !== e.pos_y) begin
                  $error("pos_y exp %0d got %0d", e.pos_y, rsp.pos_y); errors++;
               end
               if (rsp.pos_z !== e.pos_z) begin
                  $error("pos_z exp %0d got %0d", e.pos_z, rsp.pos_z); errors++;
               end
               if (rsp.dir_x !== e.dir_x) begin
                  $error("dir_x exp %0d got %0d", e.dir_x, rsp.dir_x); errors++;
               end
               if (rsp.dir_y !== e.dir_y) begin
                  $error("dir_y exp %0d got %0d", e.dir_y, rsp.dir_y); errors++;
               end
               if (rsp.dir_z !== e.dir_z) begin
                  $error("dir_z exp %0d got %0d", e.dir_z, rsp.dir_z); errors++;
               end
               if (rsp.rate_x !== e.rate_x) begin
                  $error("rate_x exp %0d got %0d", e.rate_x, rsp.rate_x); errors++;
               end
               if (rsp.rate_y !== e.rate_y) begin
                  $error("rate_y exp %0d got %0d", e.rate_y, rsp.rate_y); errors++;
               end
               if (rsp.rate_z !== e.rate_z) begin
                  $error("rate_z exp %0d got %0d", e.rate_z, rsp.rate_z); errors++;
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req.valid && req.ready) || (rsp.valid && rsp.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // receiver
   initial begin
      int stall;
      rsp.ready <= 1'b0;
      @(negedge reset);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 6);
         if (hold_off_req) begin
            stall = 300;
            hold_off_req = 0;
         end
         if (stall > 0) begin
            rsp.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp.ready <= 1'b1;
         do @(posedge clock); while (!(rsp.valid && rsp.ready));
      end
   end

   task automatic send_item(logic [PB:0] u, logic flag, logic [DW-1:0] px,
                            logic [DW-1:0] py, logic [DW-1:0] pz);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 6);
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req.valid <= 1'b1;
      req.param_u <= u;
      req.has_prev_dir <= flag;
      req.prev_dir_x <= px;
      req.prev_dir_y <= py;
      req.prev_dir_z <= pz;
      do @(posedge clock); while (!(req.valid && req.ready));
   endtask

   task automatic drain();
      req.valid <= 1'b0;
      @(posedge clock);
      while (expected_samples.size() > 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   task automatic write_csr(cbpt_pkg::csr_index_type idx, logic [3*CB-1:0] val);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      csr_wr_en <= 1'b0;
   endtask

   function automatic logic [CB-1:0] random_coord(int mode);
      case (mode)
         0: return CB'($urandom);
         1: return CB'($urandom_range(0, 400) - 200);
         2: return $urandom_range(0, 1) ? 16'h7fff : 16'h8000;
         default: return CB'($urandom_range(0, 8000) - 4000);
      endcase
   endfunction

   task automatic random_config(int mode);
      logic [3*CB-1:0] v;
      for (int j = 0; j < NCP; j++) begin
         for (int k = 0; k < 3; k++) v[CB*k +: CB] = random_coord(mode);
         write_csr(cbpt_pkg::csr_index_type'(j), v);
      end
   endtask

   function automatic logic [PB:0] random_u();
      case ($urandom_range(0, 9))
         0: return 17'($urandom);
         1: return $urandom_range(0, 1) ? 17'(U_ONE) : 17'd0;
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   task automatic random_items(int count);
      for (int i = 0; i < count; i++)
         send_item(random_u(), 1'($urandom_range(0, 1)), DW'($urandom),
                   DW'($urandom_range(0, 32768) - 16384), DW'($urandom));
   endtask

   stim_row_type zero_rows [5] = '{
      '{17'd0,      1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b1},
      '{17'd65536,  1'b1, 16'h4000, 16'hc000, 16'h0000, 1'b1},
      '{17'd131071, 1'b1, 16'h8000, 16'h7fff, 16'hffff, 1'b1},
      '{17'd1,      1'b0, 16'hffff, 16'hffff, 16'hffff, 1'b1},
      '{17'd65535,  1'b1, 16'h5555, 16'haaaa, 16'h0001, 1'b1}
   };

   stim_row_type edge_rows [8] = '{
      '{17'd0,      1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{17'd1,      1'b1, 16'h4000, 16'h4000, 16'hc000, 1'b0},
      '{17'd32768,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{17'd65535,  1'b1, 16'h7fff, 16'h8000, 16'h1234, 1'b0},
      '{17'd65536,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{17'd65537,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0},
      '{17'd131071, 1'b1, 16'hc000, 16'h0000, 16'h4000, 1'b0},
      '{17'd21845,  1'b0, 16'h0000, 16'h0000, 16'h0000, 1'b0}
   };

   initial begin
      reset <= 1'b1;
      csr_wr_en <= 1'b0;
      csr_index <= cbpt_pkg::CSR_CTRL_POINT_0;
      csr_wdata <= '0;
      req.valid <= 1'b0;
      req.param_u <= '0;
      req.has_prev_dir <= 1'b0;
      req.prev_dir_x <= '0;
      req.prev_dir_y <= '0;
      req.prev_dir_z <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset values of the control points
      foreach (zero_rows[i]) begin
         typed_now = zero_rows[i].typed;
         send_item(zero_rows[i].u, zero_rows[i].flag, zero_rows[i].px, zero_rows[i].py,
                   zero_rows[i].pz);
      end
      drain();
      typed_now = 0;

      // extreme control points
      write_csr(cbpt_pkg::CSR_CTRL_POINT_0, {3{16'h8000}});
      write_csr(cbpt_pkg::CSR_CTRL_POINT_1, {3{16'h7fff}});
      write_csr(cbpt_pkg::CSR_CTRL_POINT_2, {16'h8000, 16'h7fff, 16'h8000});
      write_csr(cbpt_pkg::CSR_CTRL_POINT_3, {3{16'h7fff}});
      foreach (edge_rows[i])
         send_item(edge_rows[i].u, edge_rows[i].flag, edge_rows[i].px, edge_rows[i].py,
                   edge_rows[i].pz);
      drain();

      // all points equal: zero derivative; indexes past 3 are ignored
      for (int j = 0; j < NCP; j++)
         write_csr(cbpt_pkg::csr_index_type'(j), {16'h0123, 16'hfedc, 16'h7fff});
      for (int j = NCP; j < 8; j++)
         write_csr(cbpt_pkg::csr_index_type'(j), 48'($urandom) ^ {$urandom, 16'h0});
      foreach (edge_rows[i])
         send_item(edge_rows[i].u, edge_rows[i].flag, edge_rows[i].px, edge_rows[i].py,
                   edge_rows[i].pz);
      drain();

      for (int ph = 0; ph < 8; ph++) begin
         random_config(ph % 4);
         if (ph == 3) hold_off_req = 1;
         no_idle = (ph == 5);
         random_items(100);
         drain();
      end
      no_idle = 0;

      if (errors == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

@@ files.f @@
hw/rtl/cbpt_pkg.sv
hw/rtl/cbpt_req_if.sv
hw/rtl/cbpt_rsp_if.sv
hw/rtl/cbpt_isqrt.sv
hw/rtl/cbpt_div.sv
hw/rtl/cubic_bezier_point_and_tangent.sv
verif/tb_cubic_bezier_point_and_tangent.sv
